[src/rne_pkg.sv]
// Package for the Roman numeral encoder: widths, ASCII letter codes and the
// per-digit letter tables. No dependencies.
package rne_pkg;

  localparam int VALUE_W  = 14;
  localparam int SYM_W    = 7;
  localparam int DIGIT_W  = 4;
  localparam int NDIGITS  = 4;
  localparam int BCD_W    = DIGIT_W * NDIGITS;
  localparam int LEN_W    = 3;
  localparam int TOTAL_W  = 4;

  localparam logic [SYM_W-1:0] CH_I = 7'h49;
  localparam logic [SYM_W-1:0] CH_V = 7'h56;
  localparam logic [SYM_W-1:0] CH_X = 7'h58;
  localparam logic [SYM_W-1:0] CH_L = 7'h4C;
  localparam logic [SYM_W-1:0] CH_C = 7'h43;
  localparam logic [SYM_W-1:0] CH_D = 7'h44;
  localparam logic [SYM_W-1:0] CH_M = 7'h4D;

  typedef enum logic [1:0] {
    ROLE_ONE  = 2'd0,
    ROLE_FIVE = 2'd1,
    ROLE_TEN  = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    PLACE_UNITS = 2'd0,
    PLACE_TENS  = 2'd1,
    PLACE_HUND  = 2'd2,
    PLACE_THOU  = 2'd3
  } place_t;

  // Status of the binary to decimal converter.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] thou;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } bcd_res_t;

  // Number of letters for one hundreds, tens or units digit.
  function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] len;
    case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // The thousands digit gives M only for one to three.
  function automatic logic [LEN_W-1:0] thou_len(input logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] len;
    case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Role of letter k within a digit.
  function automatic role_t digit_role(input logic [DIGIT_W-1:0] d,
                                       input logic [LEN_W-1:0]   k);
    role_t role;
    role = ROLE_ONE;
    if (k == '0) begin
      if (d >= 4'd5 && d <= 4'd8) begin
        role = ROLE_FIVE;
      end
    end else if (k == 3'd1) begin
      if (d == 4'd4) begin
        role = ROLE_FIVE;
      end else if (d == 4'd9) begin
        role = ROLE_TEN;
      end
    end
    return role;
  endfunction

  function automatic logic [SYM_W-1:0] place_letter(input place_t place,
                                                    input role_t  role);
    logic [SYM_W-1:0] ch;
    case (place)
      PLACE_UNITS: ch = (role == ROLE_ONE) ? CH_I : (role == ROLE_FIVE) ? CH_V : CH_X;
      PLACE_TENS:  ch = (role == ROLE_ONE) ? CH_X : (role == ROLE_FIVE) ? CH_L : CH_C;
      PLACE_HUND:  ch = (role == ROLE_ONE) ? CH_C : (role == ROLE_FIVE) ? CH_D : CH_M;
      default:     ch = CH_M;
    endcase
    return ch;
  endfunction

endpackage

[src/rne_bcd.sv]
// Iterative binary to decimal converter (shift and add-three), one input bit
// per cycle. Depends on rne_pkg.
module rne_bcd import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output bcd_res_t           res
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] shift_r, shift_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   adj;

  // Add three to every digit of five or more before the shift. Digits that
  // carry out of the thousands place are dropped, which keeps the value mod
  // ten thousand.
  always_comb begin
    for (int i = 0; i < NDIGITS; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = (bcd_r[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                                  ? bcd_r[i*DIGIT_W +: DIGIT_W] + 4'd3
                                  : bcd_r[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = value;
      bcd_nxt   = '0;
    end else if (busy_r) begin
      bcd_nxt   = {adj[BCD_W-2:0], shift_r[VALUE_W-1]};
      shift_nxt = {shift_r[VALUE_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign res.done  = done_r;
  assign res.thou  = bcd_r[3*DIGIT_W +: DIGIT_W];
  assign res.hund  = bcd_r[2*DIGIT_W +: DIGIT_W];
  assign res.tens  = bcd_r[1*DIGIT_W +: DIGIT_W];
  assign res.units = bcd_r[0*DIGIT_W +: DIGIT_W];

endmodule

[src/roman_numeral_encoder_unit.sv]
// Roman numeral encoder top level. Depends on rne_pkg and rne_bcd.
// An accepted item is converted to decimal digits in rne_bcd, the digits are
// loaded, then the walk emits one letter per result from thousands down to
// units, stepping past each digit that gives no letter. No new item is taken
// until the final result of the current one is in the output register.
// Synchronous reset empties the output.
module roman_numeral_encoder_unit import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   out_symbol,
  output logic               out_has_symbol,
  output logic               out_is_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  bcd_res_t           bcd_res;
  logic               in_fire;

  // Digits held for the emit walk.
  logic [DIGIT_W-1:0] thou_r, thou_nxt;
  logic [DIGIT_W-1:0] hund_r, hund_nxt;
  logic [DIGIT_W-1:0] tens_r, tens_nxt;
  logic [DIGIT_W-1:0] units_r, units_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] sent_r, sent_nxt;
  place_t             pos_r, pos_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_symbol_r, out_symbol_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_last_r, out_last_nxt;

  logic [DIGIT_W-1:0] cur_d;
  logic [LEN_W-1:0]   cur_len;
  logic               slot_free;
  logic               is_last_letter;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  rne_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .value (in_value),
    .res   (bcd_res)
  );

  // The digit under the walk and how many letters it gives.
  always_comb begin
    case (pos_r)
      PLACE_THOU:  cur_d = thou_r;
      PLACE_HUND:  cur_d = hund_r;
      PLACE_TENS:  cur_d = tens_r;
      default:     cur_d = units_r;
    endcase
    cur_len = (pos_r == PLACE_THOU) ? thou_len(cur_d) : digit_len(cur_d);
  end

  // The output register can take a new result when it is empty or its
  // current result leaves in this cycle.
  assign slot_free      = !out_valid_r || out_ready;
  assign is_last_letter = (TOTAL_W'(sent_r + 1'b1) == total_r);

  always_comb begin
    state_nxt      = state_r;
    thou_nxt       = thou_r;
    hund_nxt       = hund_r;
    tens_nxt       = tens_r;
    units_nxt      = units_r;
    total_nxt      = total_r;
    sent_nxt       = sent_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CONV;
        end
      end

      S_CONV: begin
        if (bcd_res.done) begin
          thou_nxt  = bcd_res.thou;
          hund_nxt  = bcd_res.hund;
          tens_nxt  = bcd_res.tens;
          units_nxt = bcd_res.units;
          total_nxt = TOTAL_W'(thou_len(bcd_res.thou))
                    + TOTAL_W'(digit_len(bcd_res.hund))
                    + TOTAL_W'(digit_len(bcd_res.tens))
                    + TOTAL_W'(digit_len(bcd_res.units));
          sent_nxt  = '0;
          pos_nxt   = PLACE_THOU;
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (total_r == '0) begin
          // A number with no letters gives one empty, final result.
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = '0;
            out_has_nxt    = 1'b0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (k_r >= cur_len) begin
          // This digit is finished; step down to the next place.
          pos_nxt = place_t'(pos_r - 1'b1);
          k_nxt   = '0;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = (pos_r == PLACE_THOU)
                           ? CH_M
                           : place_letter(pos_r, digit_role(cur_d, k_r));
          out_has_nxt    = 1'b1;
          out_last_nxt   = is_last_letter;
          k_nxt          = k_r + 1'b1;
          sent_nxt       = sent_r + 1'b1;
          if (is_last_letter) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    thou_r       <= thou_nxt;
    hund_r       <= hund_nxt;
    tens_r       <= tens_nxt;
    units_r      <= units_nxt;
    total_r      <= total_nxt;
    sent_r       <= sent_nxt;
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_has_r    <= out_has_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_symbol     = out_symbol_r;
  assign out_has_symbol = out_has_r;
  assign out_is_last    = out_last_r;

endmodule

[src/rne_checker.sv]
// Port-level checks for the Roman numeral encoder, bound to the top level.
// Depends on rne_pkg.
module rne_checker import rne_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SYM_W-1:0]   out_symbol,
  input logic               out_has_symbol,
  input logic               out_is_last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol)
      && $stable(out_has_symbol) && $stable(out_is_last))
    else $error("result changed while stalled");

  // The empty result is always the final one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_symbol |-> out_is_last && out_symbol == '0)
    else $error("empty result not marked last");

  // Every letter is one of the seven Roman letters.
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_symbol |->
      out_symbol == CH_I || out_symbol == CH_V || out_symbol == CH_X ||
      out_symbol == CH_L || out_symbol == CH_C || out_symbol == CH_D ||
      out_symbol == CH_M)
    else $error("result is not a Roman letter");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while converting");

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_symbol     (out_symbol),
  .out_has_symbol (out_has_symbol),
  .out_is_last    (out_is_last)
);
